/* sv/mvt_pkg.sv */
// Shared types, constants and constant functions of the mesh vertex tension block.
// Used by the interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package mvt_pkg;

  // Fixed formats of the result beat and of the log-domain arithmetic.
  localparam int LOG_FRAC  = 20;
  localparam int SUM_W     = 48;
  localparam int IDX_W     = 20;
  localparam int TEN_W     = 18;
  localparam int COL_W     = 17;
  localparam int MANT_W    = 32;
  localparam int DIV_STEPS = SUM_W;
  localparam int EXP_LIMIT = 40;
  localparam int STEP_W    = 6;

  // Log2 value given to a deformed edge of zero length.
  localparam logic [SUM_W-1:0] ZERO_LOG = -(SUM_W'(1) << (LOG_FRAC + 16));

  // Default parameter values.
  localparam int DEF_COORD_WIDTH   = 32;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_MAX_NEIGHBORS = 64;
  localparam int DEF_MAX_VERTICES  = 1048576;

  // Item kinds on the input channel.
  localparam logic CMD_CENTER   = 1'b0;
  localparam logic CMD_NEIGHBOR = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAG,
    OP_MUL,
    OP_ACC,
    OP_DEGEN,
    OP_LZ,
    OP_NORM,
    OP_LSQ,
    OP_LACC,
    OP_DIVI,
    OP_DIVS,
    OP_EXPI,
    OP_EXPS,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
    logic              zero_res;
  } dp_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic in_last;
    logic count_full;
    logic sqn_zero;
    logic last_r;
    logic end_zero;
    logic out_free;
  } dp_stat_t;

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    rem   = n;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > rem) begin
        bit_v = bit_v >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (rem >= res + bit_v) begin
          rem = rem - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // Q0.32 value of 2^-(2^-(j+1)), built by the chain of square roots.
  function automatic logic [MANT_W-1:0] exp_const(input int j);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int i = 0; i < LOG_FRAC; i++) begin
      if (i < j) begin
        c = isqrt64(c << 32);
      end
    end
    return c[MANT_W-1:0];
  endfunction

endpackage

/* sv/mvt_if.sv */
// Handshake interfaces of the mesh vertex tension block: vertex item input and result output.
// Depends on mvt_pkg for the result field widths.
interface mvt_in_if #(
  parameter int COORD_WIDTH = mvt_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [COORD_WIDTH-1:0] neutral_x;
  logic signed [COORD_WIDTH-1:0] neutral_y;
  logic signed [COORD_WIDTH-1:0] neutral_z;
  logic signed [COORD_WIDTH-1:0] deformed_x;
  logic signed [COORD_WIDTH-1:0] deformed_y;
  logic signed [COORD_WIDTH-1:0] deformed_z;
  logic                          last_edge;

  modport source (
    output valid, cmd, neutral_x, neutral_y, neutral_z,
    output deformed_x, deformed_y, deformed_z, last_edge,
    input  ready
  );
  modport sink (
    input  valid, cmd, neutral_x, neutral_y, neutral_z,
    input  deformed_x, deformed_y, deformed_z, last_edge,
    output ready
  );
endinterface

interface mvt_out_if;
  logic                              valid;
  logic                              ready;
  logic [mvt_pkg::IDX_W-1:0]         vertex_index;
  logic signed [mvt_pkg::TEN_W-1:0]  tension;
  logic [mvt_pkg::COL_W-1:0]         red;
  logic [mvt_pkg::COL_W-1:0]         green;
  logic                              degenerate;

  modport source (
    output valid, vertex_index, tension, red, green, degenerate,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, tension, red, green, degenerate,
    output ready
  );
endinterface

/* sv/mvt_ctrl.sv */
// Controller of the mesh vertex tension block: sequences edge, log, divide and exp steps.
// Depends on mvt_pkg for the command and status structs.
module mvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mvt_pkg::dp_stat_t stat,
  output mvt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_MAG  = 16'h0002,
    S_MUL  = 16'h0004,
    S_ACC  = 16'h0008,
    S_CHK  = 16'h0010,
    S_LZ   = 16'h0020,
    S_NORM = 16'h0040,
    S_LOG  = 16'h0080,
    S_LACC = 16'h0100,
    S_TAIL = 16'h0200,
    S_END  = 16'h0400,
    S_DIVI = 16'h0800,
    S_DIV  = 16'h1000,
    S_EXPI = 16'h2000,
    S_EXP  = 16'h4000,
    S_EMIT = 16'h8000
  } state_t;

  localparam logic [mvt_pkg::STEP_W-1:0] LAST_ELEM = mvt_pkg::STEP_W'(2);
  localparam logic [mvt_pkg::STEP_W-1:0] LAST_LOG  = mvt_pkg::STEP_W'(mvt_pkg::LOG_FRAC - 1);
  localparam logic [mvt_pkg::STEP_W-1:0] LAST_DIV  = mvt_pkg::STEP_W'(mvt_pkg::DIV_STEPS - 1);

  state_t                      state_r, state_nxt;
  logic [mvt_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        zero_r, zero_nxt;

  // Next state and the operation issued to the datapath.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    zero_nxt     = zero_r;
    in_ready     = 1'b0;
    cmd.op       = mvt_pkg::OP_NONE;
    cmd.step     = step_r;
    cmd.zero_res = zero_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = mvt_pkg::OP_LOAD;
          step_nxt = '0;
          if (stat.in_cmd == mvt_pkg::CMD_CENTER) begin
            zero_nxt  = 1'b1;
            state_nxt = stat.in_last ? S_EMIT : S_IDLE;
          end else if (!stat.count_full) begin
            state_nxt = S_MAG;
          end else if (stat.in_last) begin
            state_nxt = S_END;
          end
        end
      end
      S_MAG: begin
        cmd.op    = mvt_pkg::OP_MAG;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = mvt_pkg::OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = mvt_pkg::OP_ACC;
        if (step_r == LAST_ELEM) begin
          step_nxt  = '0;
          state_nxt = S_CHK;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = S_MAG;
        end
      end
      S_CHK: begin
        if (stat.sqn_zero) begin
          cmd.op    = mvt_pkg::OP_DEGEN;
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_LZ;
        end
      end
      S_LZ: begin
        cmd.op    = mvt_pkg::OP_LZ;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.op    = mvt_pkg::OP_NORM;
        step_nxt  = '0;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.op = mvt_pkg::OP_LSQ;
        if (step_r == LAST_LOG) begin
          step_nxt  = '0;
          state_nxt = S_LACC;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LACC: begin
        cmd.op    = mvt_pkg::OP_LACC;
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        state_nxt = stat.last_r ? S_END : S_IDLE;
      end
      S_END: begin
        if (stat.end_zero) begin
          zero_nxt  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.op    = mvt_pkg::OP_DIVI;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = mvt_pkg::OP_DIVS;
        if (step_r == LAST_DIV) begin
          step_nxt  = '0;
          state_nxt = S_EXPI;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_EXPI: begin
        cmd.op    = mvt_pkg::OP_EXPI;
        step_nxt  = '0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        cmd.op = mvt_pkg::OP_EXPS;
        if (step_r == LAST_LOG) begin
          step_nxt  = '0;
          zero_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = mvt_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule

/* sv/mvt_dp.sv */
// Datapath of the mesh vertex tension block: edge lengths, two log2 lanes, divider,
// exp2 product and the result register. Depends on mvt_pkg.
module mvt_dp #(
  parameter int COORD_WIDTH   = mvt_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS     = mvt_pkg::DEF_FRAC_BITS,
  parameter int MAX_NEIGHBORS = mvt_pkg::DEF_MAX_NEIGHBORS,
  parameter int MAX_VERTICES  = mvt_pkg::DEF_MAX_VERTICES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_cmd,
  input  logic signed [COORD_WIDTH-1:0]     in_neutral_x,
  input  logic signed [COORD_WIDTH-1:0]     in_neutral_y,
  input  logic signed [COORD_WIDTH-1:0]     in_neutral_z,
  input  logic signed [COORD_WIDTH-1:0]     in_deformed_x,
  input  logic signed [COORD_WIDTH-1:0]     in_deformed_y,
  input  logic signed [COORD_WIDTH-1:0]     in_deformed_z,
  input  logic                              in_last_edge,
  input  mvt_pkg::dp_cmd_t                  cmd,
  output mvt_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mvt_pkg::IDX_W-1:0]         out_vertex_index,
  output logic signed [mvt_pkg::TEN_W-1:0]  out_tension,
  output logic [mvt_pkg::COL_W-1:0]         out_red,
  output logic [mvt_pkg::COL_W-1:0]         out_green,
  output logic                              out_degenerate
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = PROD_W + 2;
  localparam int EW     = $clog2(SQ_W);
  localparam int NW     = $clog2(MAX_NEIGHBORS + 1);
  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int XW     = (VW > mvt_pkg::IDX_W) ? VW : mvt_pkg::IDX_W;
  localparam int MW     = mvt_pkg::MANT_W;
  localparam int LF     = mvt_pkg::LOG_FRAC;
  localparam int SW     = mvt_pkg::SUM_W;
  localparam int PW     = MW + 1;
  localparam int MAG_W  = FRAC_BITS + 2;
  localparam int WIDE_W = 32;

  // Index of the highest set bit (zero for a zero word).
  function automatic logic [EW-1:0] msb_index(input logic [SQ_W-1:0] v);
    logic [EW-1:0] r;
    r = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (v[i]) begin
        r = EW'(i);
      end
    end
    return r;
  endfunction

  // Exp2 constants, one per fraction bit of the log.
  logic [MW-1:0] exp_tab [LF];
  for (genvar j = 0; j < LF; j++) begin : g_exp
    localparam logic [MW-1:0] CJ = mvt_pkg::exp_const(j);
    assign exp_tab[j] = CJ;
  end

  // Stored center and the current neighbor item.
  logic signed [COORD_WIDTH-1:0] cn_r [3];
  logic signed [COORD_WIDTH-1:0] cd_r [3];
  logic signed [COORD_WIDTH-1:0] nn_r [3];
  logic signed [COORD_WIDTH-1:0] nd_r [3];
  logic                          last_r;

  // Edge length lanes.
  logic [DIFF_W-1:0] mag_n_r, mag_d_r;
  logic [PROD_W-1:0] prod_n_r, prod_d_r;
  logic [SQ_W-1:0]   sq_n_r, sq_d_r;

  // Log2 lanes.
  logic [EW-1:0]     e_n_r, e_d_r;
  logic [MW-1:0]     m_n_r, m_d_r;
  logic [LF-1:0]     f_n_r, f_d_r;

  // Per-vertex state.
  logic [SW-1:0]     sum_r;
  logic [NW-1:0]     count_r;
  logic              degen_r;
  logic [VW-1:0]     vcnt_r;

  // Divider and exp2.
  logic [NW:0]       rem_r;
  logic [SW-1:0]     quo_r;
  logic              neg_r;
  logic [PW-1:0]     p_r;

  // Result register.
  logic              out_valid_r;
  logic [mvt_pkg::IDX_W-1:0]        idx_r;
  logic signed [mvt_pkg::TEN_W-1:0] ten_r;
  logic [mvt_pkg::COL_W-1:0]        red_r, green_r;
  logic              deg_out_r;

  // Element differences for the selected coordinate.
  logic [1:0]               sel;
  logic signed [DIFF_W-1:0] dn, dd;
  assign sel = cmd.step[1:0];
  assign dn  = DIFF_W'(nn_r[sel]) - DIFF_W'(cn_r[sel]);
  assign dd  = DIFF_W'(nd_r[sel]) - DIFF_W'(cd_r[sel]);

  // Mantissa from the normalized squared length.
  logic [SQ_W-1:0] sh_n, sh_d;
  assign sh_n = sq_n_r << (EW'(SQ_W - 1) - e_n_r);
  assign sh_d = sq_d_r << (EW'(SQ_W - 1) - e_d_r);

  // One squaring step of each log lane.
  logic [2*MW-1:0] msq_n, msq_d;
  logic [MW:0]     s_n, s_d;
  assign msq_n = m_n_r * m_n_r;
  assign msq_d = m_d_r * m_d_r;
  assign s_n   = msq_n[2*MW-1:MW-1];
  assign s_d   = msq_d[2*MW-1:MW-1];

  // Log sum update.
  logic [SW-1:0] ld, lr;
  assign ld = (sq_d_r == '0) ? mvt_pkg::ZERO_LOG : SW'({e_d_r, f_d_r});
  assign lr = SW'({e_n_r, f_n_r});

  // Restoring divide step by twice the neighbor count.
  logic [NW+1:0] div_t, div_d;
  logic          div_ge;
  assign div_t  = {rem_r, quo_r[SW-1]};
  assign div_d  = (NW + 2)'({count_r, 1'b0});
  assign div_ge = (div_t >= div_d);

  // Exp2 product step.
  logic [4:0]       ej;
  logic [PW+MW-1:0] pc;
  logic             fbit;
  assign ej   = cmd.step[4:0];
  assign pc   = p_r * exp_tab[ej];
  assign fbit = quo_r[LF - 1 - 32'(ej)];

  // Final rounding into the tension magnitude.
  logic [SW-LF-1:0] kint;
  logic [PW-1:0]    pk;
  logic [PW:0]      rnd;
  logic [MAG_W-1:0] rq, mag;
  logic             ten_neg;
  logic [WIDE_W-1:0] mag_w, ten_w;
  assign kint    = quo_r[SW-1:LF];
  assign pk      = (kint >= (SW - LF)'(mvt_pkg::EXP_LIMIT)) ? '0 : (p_r >> kint[5:0]);
  assign rnd     = (PW + 1)'(pk) + ((PW + 1)'(1) << (31 - FRAC_BITS));
  assign rq      = MAG_W'(rnd >> (32 - FRAC_BITS));
  assign mag     = (MAG_W'(1) << FRAC_BITS) - rq;
  assign ten_neg = neg_r && (mag != '0);
  assign mag_w   = WIDE_W'(mag);
  assign ten_w   = ten_neg ? (~mag_w + 1'b1) : mag_w;

  logic [XW-1:0] vx;
  assign vx = XW'(vcnt_r);

  // Status to the controller.
  assign stat.in_cmd     = in_cmd;
  assign stat.in_last    = in_last_edge;
  assign stat.count_full = (count_r >= NW'(MAX_NEIGHBORS));
  assign stat.sqn_zero   = (sq_n_r == '0);
  assign stat.last_r     = last_r;
  assign stat.end_zero   = degen_r || (count_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

  // Control state: center, sums, counters and the result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cn_r[i] <= '0;
        cd_r[i] <= '0;
      end
      sum_r       <= '0;
      count_r     <= '0;
      degen_r     <= 1'b0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A beat leaving with no new result behind it empties the output register.
      if (out_valid_r && out_ready && cmd.op != mvt_pkg::OP_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        mvt_pkg::OP_LOAD: begin
          if (in_cmd == mvt_pkg::CMD_CENTER) begin
            cn_r[0] <= in_neutral_x;
            cn_r[1] <= in_neutral_y;
            cn_r[2] <= in_neutral_z;
            cd_r[0] <= in_deformed_x;
            cd_r[1] <= in_deformed_y;
            cd_r[2] <= in_deformed_z;
            sum_r   <= '0;
            count_r <= '0;
            degen_r <= 1'b0;
          end else if (!stat.count_full) begin
            count_r <= count_r + 1'b1;
          end
        end
        mvt_pkg::OP_DEGEN: begin
          degen_r <= 1'b1;
        end
        mvt_pkg::OP_LACC: begin
          sum_r <= sum_r + ld - lr;
        end
        mvt_pkg::OP_EMIT: begin
          out_valid_r <= 1'b1;
          sum_r       <= '0;
          count_r     <= '0;
          degen_r     <= 1'b0;
          vcnt_r      <= (vcnt_r == VW'(MAX_VERTICES - 1)) ? '0 : vcnt_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers of the arithmetic lanes and the result beat.
  always_ff @(posedge clk) begin
    case (cmd.op)
      mvt_pkg::OP_LOAD: begin
        nn_r[0] <= in_neutral_x;
        nn_r[1] <= in_neutral_y;
        nn_r[2] <= in_neutral_z;
        nd_r[0] <= in_deformed_x;
        nd_r[1] <= in_deformed_y;
        nd_r[2] <= in_deformed_z;
        last_r  <= in_last_edge;
        sq_n_r  <= '0;
        sq_d_r  <= '0;
      end
      mvt_pkg::OP_MAG: begin
        mag_n_r <= dn[DIFF_W-1] ? DIFF_W'(-dn) : DIFF_W'(dn);
        mag_d_r <= dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
      end
      mvt_pkg::OP_MUL: begin
        prod_n_r <= mag_n_r * mag_n_r;
        prod_d_r <= mag_d_r * mag_d_r;
      end
      mvt_pkg::OP_ACC: begin
        sq_n_r <= sq_n_r + SQ_W'(prod_n_r);
        sq_d_r <= sq_d_r + SQ_W'(prod_d_r);
      end
      mvt_pkg::OP_LZ: begin
        e_n_r <= msb_index(sq_n_r);
        e_d_r <= msb_index(sq_d_r);
      end
      mvt_pkg::OP_NORM: begin
        m_n_r <= sh_n[SQ_W-1 -: MW];
        m_d_r <= sh_d[SQ_W-1 -: MW];
        f_n_r <= '0;
        f_d_r <= '0;
      end
      mvt_pkg::OP_LSQ: begin
        m_n_r <= s_n[MW] ? s_n[MW:1] : s_n[MW-1:0];
        m_d_r <= s_d[MW] ? s_d[MW:1] : s_d[MW-1:0];
        f_n_r <= {f_n_r[LF-2:0], s_n[MW]};
        f_d_r <= {f_d_r[LF-2:0], s_d[MW]};
      end
      mvt_pkg::OP_DIVI: begin
        neg_r <= sum_r[SW-1];
        quo_r <= sum_r[SW-1] ? (~sum_r + 1'b1) : sum_r;
        rem_r <= '0;
      end
      mvt_pkg::OP_DIVS: begin
        rem_r <= div_ge ? (NW + 1)'(div_t - div_d) : div_t[NW:0];
        quo_r <= {quo_r[SW-2:0], div_ge};
      end
      mvt_pkg::OP_EXPI: begin
        p_r <= PW'(1) << MW;
      end
      mvt_pkg::OP_EXPS: begin
        if (fbit) begin
          p_r <= pc[PW+MW-1:MW];
        end
      end
      mvt_pkg::OP_EMIT: begin
        idx_r <= vx[mvt_pkg::IDX_W-1:0];
        if (cmd.zero_res) begin
          ten_r     <= '0;
          red_r     <= '0;
          green_r   <= '0;
          deg_out_r <= degen_r;
        end else begin
          ten_r     <= ten_w[mvt_pkg::TEN_W-1:0];
          red_r     <= ten_neg ? mag_w[mvt_pkg::COL_W-1:0] : '0;
          green_r   <= ten_neg ? '0 : mag_w[mvt_pkg::COL_W-1:0];
          deg_out_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = idx_r;
  assign out_tension      = ten_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_degenerate   = deg_out_r;

endmodule

/* sv/mesh_vertex_tension.sv */
// Top level of the mesh vertex tension block: joins controller and datapath to the channels.
// Depends on mvt_pkg, mvt_if, mvt_ctrl and mvt_dp.
//
// Usage: a vertex is sent as one center beat (cmd 0) on in_ch followed by one beat per
// neighbor (cmd 1); last_edge on a neighbor beat closes the vertex, and on a center
// beat it closes a vertex without neighbors. One result beat per closed vertex leaves
// on out_ch with the vertex index, the Q1.16 tension, red/green intensities and the
// degenerate flag.
// Steps: a center beat stores the center; when it closes a vertex without neighbors the
// result is emitted. A summed neighbor forms the three squared component products of both
// edges, normalizes, runs 20 squaring steps of the two log2 lanes, and does bookkeeping.
// Closing a vertex runs 48 steps of the restoring divider for the mean log and 20
// multiply steps of the exp2 product; a degenerate vertex skips both. A neighbor beyond
// the limit is taken without being summed; a zero rest edge marks the vertex degenerate.
// Reset (synchronous, active low) clears the stored center, sums and index counter.
// The result sits in an output register; while it waits for out_ch.ready, input is
// still taken, and the controller only holds when a second result is ready to leave.
module mesh_vertex_tension #(
  parameter int COORD_WIDTH   = mvt_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS     = mvt_pkg::DEF_FRAC_BITS,
  parameter int MAX_NEIGHBORS = mvt_pkg::DEF_MAX_NEIGHBORS,
  parameter int MAX_VERTICES  = mvt_pkg::DEF_MAX_VERTICES
) (
  input  logic      clk,
  input  logic      rst_n,
  mvt_in_if.sink    in_ch,
  mvt_out_if.source out_ch
);

  mvt_pkg::dp_cmd_t  cmd;
  mvt_pkg::dp_stat_t stat;
  logic              ready;

  // Sequencer.
  mvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = ready;

  // Arithmetic and result register.
  mvt_dp #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .MAX_VERTICES  (MAX_VERTICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_ch.cmd),
    .in_neutral_x     (in_ch.neutral_x),
    .in_neutral_y     (in_ch.neutral_y),
    .in_neutral_z     (in_ch.neutral_z),
    .in_deformed_x    (in_ch.deformed_x),
    .in_deformed_y    (in_ch.deformed_y),
    .in_deformed_z    (in_ch.deformed_z),
    .in_last_edge     (in_ch.last_edge),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_vertex_index (out_ch.vertex_index),
    .out_tension      (out_ch.tension),
    .out_red          (out_ch.red),
    .out_green        (out_ch.green),
    .out_degenerate   (out_ch.degenerate)
  );

endmodule
